// ===== rtl/core/bfloat16_add_sub_macros.svh =====
// ----------------------------------------------------------------------------
// bf16 adder assertion macros
// shared property wrappers for the rtl assertions
// ----------------------------------------------------------------------------
`ifndef BFLOAT16_ADD_SUB_MACROS_SVH
`define BFLOAT16_ADD_SUB_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/bfas_pkg.sv =====
// ----------------------------------------------------------------------------
// bf16 adder package
// stage payload types and constants
// ----------------------------------------------------------------------------
package bfas_pkg;
  localparam logic [15:0] QNAN     = 16'h7FC0;
  localparam logic [14:0] INF_MAG  = 15'h7F80;
  localparam logic [7:0]  EXP_MAX  = 8'hFF;

  // after unpack / special-case detection
  typedef struct packed {
    logic        done;
    logic [15:0] res;
    logic        sa;
    logic        sb;
    logic [7:0]  re;
    logic [7:0]  ma;
    logic [7:0]  mb;
  } s1_t;

  // after add or subtract of aligned mantissas
  typedef struct packed {
    logic        done;
    logic [15:0] res;
    logic        rs;
    logic        add;
    logic [7:0]  re;
    logic [8:0]  rm;
  } s2_t;
endpackage

// ===== rtl/core/bfloat16_add_sub.sv =====
// ----------------------------------------------------------------------------
// bfloat16 adder / subtractor
// truncating bf16 add or subtract, three-stage pipeline
// ----------------------------------------------------------------------------
// usage:
//   input channel in_*: tdata carries {operand_b, operand_a, func} with func
//   in bit 0; out_* tdata carries sum_bits.
//   one item per cycle sustained while the receiver takes outputs; three register
//   stages (align, mantissa add, normalize), the first loaded at the accepting
//   edge; out_tvalid rises when the item reaches the normalize register.
//   every stage is a register; each stage advances when the stage after it is
//   empty or advancing, so a stall holds items while gaps ahead of them close up.
//   in_tready is low only while the output holds an item the receiver stalls
//   and the pipe is full up to it.
//   reset clears all valid bits; no item is in flight afterwards.
// ----------------------------------------------------------------------------
`include "bfloat16_add_sub_macros.svh"
module bfloat16_add_sub (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // func, operand_a, operand_b, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // sum_bits
);
  import bfas_pkg::*;
  s1_t s1_c, s1_r;
  s2_t s2_c, s2_r;
  logic [15:0] res_c, out_r;
  logic v1_r, v2_r, v3_r;
  logic adv3, adv2, adv1;

  assign adv3 = !v3_r || out_tready;
  assign adv2 = adv3 || !v2_r;
  assign adv1 = adv2 || !v1_r;
  assign in_tready = adv1;

  bfas_align u_align (
    .func (in_tdata[0]),
    .a    (in_tdata[16:1]),
    .b_in (in_tdata[32:17]),
    .s1   (s1_c)
  );
  bfas_addsub u_addsub (.s1(s1_r), .s2(s2_c));
  bfas_norm   u_norm   (.s2(s2_r), .res(res_c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1_r <= s1_c;
    if (adv2) s2_r <= s2_c;
    if (adv3) out_r <= res_c;
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = out_r;

  `BF_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BF_ASSERT_IMP(a_ready, clk, rst_n, !in_tready, v1_r && v2_r && v3_r && !out_tready)
  `BF_ASSERT_NXT(a_flow, clk, rst_n, v2_r && adv3, out_tvalid)
endmodule

// ===== rtl/core/bfas_align.sv =====
// ----------------------------------------------------------------------------
// bf16 adder align stage
// special cases, hidden bits and truncating alignment
// ----------------------------------------------------------------------------
module bfas_align (
  input  logic              func,
  input  logic [15:0]       a,
  input  logic [15:0]       b_in,
  output bfas_pkg::s1_t     s1
);
  import bfas_pkg::*;
  logic [15:0] b;
  logic       sa, sb;
  logic [7:0] ea, eb, ma, mb, diff;
  logic       a_ge;

  always_comb begin
    b  = {b_in[15] ^ func, b_in[14:0]};
    sa = a[15];
    sb = b[15];
    ea = a[14:7];
    eb = b[14:7];
    ma = {ea != 8'd0, a[6:0]};
    mb = {eb != 8'd0, b[6:0]};
    a_ge = ea >= eb;
    diff = a_ge ? (ea - eb) : (eb - ea);
    s1 = '0;
    s1.sa = sa;
    s1.sb = sb;
    s1.re = a_ge ? ea : eb;
    s1.ma = a_ge ? ma : (ma >> diff);
    s1.mb = a_ge ? (mb >> diff) : mb;
    if (ea == EXP_MAX) begin
      s1.done = 1'b1;
      if (a[6:0] != 7'd0) s1.res = a;
      else if (eb == EXP_MAX) s1.res = (b[6:0] != 7'd0 || sa == sb) ? b : QNAN;
      else s1.res = a;
    end else if (eb == EXP_MAX) begin
      s1.done = 1'b1; s1.res = b;
    end else if (a[14:0] == 15'd0) begin
      s1.done = 1'b1; s1.res = b;
    end else if (b[14:0] == 15'd0) begin
      s1.done = 1'b1; s1.res = a;
    end else if (diff > 8'd8) begin
      s1.done = 1'b1; s1.res = a_ge ? a : b;
    end
  end
endmodule

// ===== rtl/core/bfas_addsub.sv =====
// ----------------------------------------------------------------------------
// bf16 adder mantissa stage
// magnitude add or subtract and result sign
// ----------------------------------------------------------------------------
module bfas_addsub (
  input  bfas_pkg::s1_t s1,
  output bfas_pkg::s2_t s2
);
  import bfas_pkg::*;
  always_comb begin
    s2.done = s1.done;
    s2.res  = s1.res;
    s2.re   = s1.re;
    s2.add  = s1.sa == s1.sb;
    if (s1.sa == s1.sb) begin
      s2.rs = s1.sa;
      s2.rm = {1'b0, s1.ma} + {1'b0, s1.mb};
    end else if (s1.ma >= s1.mb) begin
      s2.rs = s1.sa;
      s2.rm = {1'b0, s1.ma - s1.mb};
    end else begin
      s2.rs = s1.sb;
      s2.rm = {1'b0, s1.mb - s1.ma};
    end
  end
endmodule

// ===== rtl/core/bfas_norm.sv =====
// ----------------------------------------------------------------------------
// bf16 adder normalize stage
// carry renormalize, leading-zero shift and result packing
// ----------------------------------------------------------------------------
module bfas_norm (
  input  bfas_pkg::s2_t s2,
  output logic [15:0]   res
);
  import bfas_pkg::*;
  logic [3:0] lz;
  logic [8:0] re1;
  logic [7:0] sh;

  always_comb begin
    lz = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (s2.rm[i]) lz = 4'(7 - i);
    end
    re1 = {1'b0, s2.re} + 9'd1;
    sh  = s2.rm[7:0] << lz;
    if (s2.done) begin
      res = s2.res;
    end else if (s2.add) begin
      if (s2.rm[8]) begin
        if (re1 >= {1'b0, EXP_MAX}) res = {s2.rs, INF_MAG};
        else res = {s2.rs, re1[7:0], s2.rm[7:1]};
      end else begin
        res = {s2.rs, s2.re, s2.rm[6:0]};
      end
    end else if (s2.rm[7:0] == 8'd0) begin
      res = 16'd0;
    end else if ({4'd0, lz} >= s2.re) begin
      // exponent would hit zero during the shift
      res = 16'd0;
    end else begin
      res = {s2.rs, s2.re - {4'd0, lz}, sh[6:0]};
    end
  end
endmodule

// ===== tb/bfloat16_add_sub_checker.sv =====
// ----------------------------------------------------------------------------
// bf16 adder result checker
// watches both streams, predicts each sum and compares it in order
// ----------------------------------------------------------------------------
module bfloat16_add_sub_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          fail_count,
  output int          pending_sums,
  output int          checked_sums
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {OP_ADD = 1'b0, OP_SUB = 1'b1} op_e;

  logic [15:0] expected_sums[$];

  function automatic logic [15:0] bf16_truncating_sum(logic [15:0] a, logic [15:0] b);
    logic       sa, sb, rs;
    logic [7:0] ea, eb;
    logic [8:0] ma, mb, rm;
    int         re, gap;
    sa = a[15];
    sb = b[15];
    ea = a[14:7];
    eb = b[14:7];
    ma = {2'b0, a[6:0]};
    mb = {2'b0, b[6:0]};
    if (ea == 8'hFF) begin
      if (ma != 0) return a;
      if (eb == 8'hFF) return (mb != 0 || sa == sb) ? b : bfas_pkg::QNAN;
      return a;
    end
    if (eb == 8'hFF) return b;
    if (ea == 0 && ma == 0) return b;
    if (eb == 0 && mb == 0) return a;
    if (ea != 0) ma[7] = 1'b1;
    if (eb != 0) mb[7] = 1'b1;
    gap = int'(ea) - int'(eb);
    re = (gap < 0) ? int'(eb) : int'(ea);
    if (gap > 8) return a;
    if (gap < -8) return b;
    if (gap > 0) mb = mb >> gap;
    if (gap < 0) ma = ma >> (-gap);
    if (sa == sb) begin
      rs = sa;
      rm = ma + mb;
      if (rm[8]) begin
        rm = rm >> 1;
        re++;
        if (re >= 255) return {rs, bfas_pkg::INF_MAG};
      end
    end else begin
      rs = (ma >= mb) ? sa : sb;
      rm = (ma >= mb) ? ma - mb : mb - ma;
      if (rm == 0) return 16'h0000;
      while (!rm[7]) begin
        rm = rm << 1;
        re--;
        if (re <= 0) return 16'h0000;
      end
    end
    return {rs, re[7:0], rm[6:0]};
  endfunction

  always @(posedge clk) begin
    logic [15:0] b_eff;
    logic [15:0] want;
    if (!rst_n) begin
      fail_count   <= 0;
      checked_sums <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        b_eff = in_tdata[32:17];
        if (op_e'(in_tdata[0]) == OP_SUB) b_eff[15] = ~b_eff[15];
        expected_sums.push_back(bf16_truncating_sum(in_tdata[16:1], b_eff));
      end
      if (out_tvalid && out_tready) begin
        checked_sums <= checked_sums + 1;
        if (expected_sums.size() == 0) begin
          if (fail_count < 10) $display("unexpected sum %h with nothing pending", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_sums.pop_front();
          if (want !== out_tdata) begin
            if (fail_count < 10)
              $display("sum mismatch: expected %h got %h", want, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_sums <= expected_sums.size();
  end
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// bf16 adder testbench
// directed special values then random operand pairs with random idling
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  int          fail_count, pending_sums, checked_sums;
  logic        rx_hold = 1'b0;
  logic        rx_calm = 1'b0;
  logic        tx_done = 1'b0;

  always #5 clk = ~clk;

  bfloat16_add_sub DUT (.*);

  bfloat16_add_sub_checker checker_i (.*);

  // pick an interesting bf16 value: specials, tiny, huge, zero or mid-range
  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    v = 16'($urandom());
    case ($urandom_range(0, 9))
      0: v[14:7] = 8'hFF;
      1: v[14:7] = 8'h00;
      2: v[14:7] = 8'hFE;
      3: v[14:0] = 15'h0;
      default: v[14:7] = 8'(8'h78 + $urandom_range(0, 16));
    endcase
    return v;
  endfunction

  task automatic send_item(logic op, logic [15:0] a, logic [15:0] b, bit gaps);
    if (gaps && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 33) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, b, a, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    logic [15:0] dir_a[16] = '{16'h3F80, 16'h7F7F, 16'hFF7F, 16'h7FC1, 16'h7F80, 16'h7F80,
                               16'h7F80, 16'h0000, 16'h3F80, 16'h4B00, 16'h3F80, 16'h3F80,
                               16'h0001, 16'h007F, 16'h3F81, 16'h0080};
    logic [15:0] dir_b[16] = '{16'h3F80, 16'h7F7F, 16'hFF7F, 16'h3F80, 16'h7F80, 16'hFF80,
                               16'h4000, 16'hBF80, 16'h8000, 16'h3F80, 16'h7FC0, 16'hBF80,
                               16'h0002, 16'h007F, 16'h3F80, 16'h0081};
    logic [15:0] a, b;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_a[i]) begin
      send_item(1'b0, dir_a[i], dir_b[i], 1'b1);
      send_item(1'b1, dir_a[i], dir_b[i], 1'b1);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      a = pick_operand();
      b = ($urandom_range(0, 3) == 0) ? {a[15:7] + 9'($urandom_range(0, 2)), 7'($urandom())}
                                      : pick_operand();
      send_item(1'($urandom()), a, b, !(n >= 400 && n < 600));
    end
    in_tvalid <= 1'b0;
    tx_done <= 1'b1;
    while (pending_sums != 0 || in_tvalid) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d results over directed specials and %0d random pairs",
             checked_sums, RANDOM_ITEMS);
    if (fail_count == 0 && pending_sums == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver stall: one long hold-off mid run, a calm stretch, else random
  initial begin
    repeat (300) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (60) @(posedge clk);
    rx_hold <= 1'b0;
    repeat (200) @(posedge clk);
    rx_calm <= 1'b1;
    repeat (400) @(posedge clk);
    rx_calm <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= rx_calm || tx_done || ($urandom_range(0, 99) >= 33);
    end
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
